// ===== rtl/core/bllca_pkg.sv =====
// Shared types, constants and helpers for the binary lifting LCA engine.
package bllca_pkg;

  localparam int NODES_DEF      = 1024;
  localparam int LOG_LEVELS_DEF = 10;

  localparam int NODE_W   = 10;
  localparam int DEPTH_W  = 10;
  localparam int ENTRY_W  = NODE_W + 1;
  localparam int CNT_W    = 11;
  localparam int LVL_W    = 5;
  localparam int NADDR_W  = 16;
  localparam int OP_W     = 2;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 16;
  localparam logic [CNT_W-1:0] NODE_COUNT_RST = 11'd1024;

  localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
  localparam logic [OP_W-1:0] OP_BUILD  = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_B_CHK,
    S_B_RD2,
    S_B_WR,
    S_Q_DB,
    S_Q_SW,
    S_Q_LIFT,
    S_Q_LIFTW,
    S_Q_DSA,
    S_Q_DSB,
    S_Q_DCMP,
    S_Q_TOP,
    S_Q_TOPW,
    S_OUT
  } state_t;

  // request into the ancestor table
  typedef struct packed {
    logic               rd_en;
    logic [LVL_W-1:0]   rd_lvl;
    logic [NADDR_W-1:0] rd_node;
    logic               wr_en;
    logic [LVL_W-1:0]   wr_lvl;
    logic [NADDR_W-1:0] wr_node;
    logic [ENTRY_W-1:0] wr_data;
  } tbl_req_t;

  // request into the depth store
  typedef struct packed {
    logic               rd_en;
    logic [NODE_W-1:0]  rd_node;
    logic               wr_en;
    logic [NODE_W-1:0]  wr_node;
    logic [DEPTH_W-1:0] wr_data;
  } dep_req_t;

  // position of the highest set bit, zero for zero
  function automatic logic [LVL_W-1:0] msb_pos(input logic [DEPTH_W-1:0] d);
    logic [LVL_W-1:0] p;
    p = '0;
    for (int k = 0; k < DEPTH_W; k++) begin
      if (d[k]) p = LVL_W'(k);
    end
    return p;
  endfunction

endpackage

// ===== rtl/core/bllca_table.sv =====
// Ancestor table memory: level-major, one read and one write per cycle.
module bllca_table #(
  parameter int NODES      = bllca_pkg::NODES_DEF,
  parameter int LOG_LEVELS = bllca_pkg::LOG_LEVELS_DEF
) (
  input  logic                           clk,
  input  bllca_pkg::tbl_req_t            req,
  output logic [bllca_pkg::ENTRY_W-1:0]  rd_data
);
  localparam int NW    = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int LW    = (LOG_LEVELS > 0) ? $clog2(LOG_LEVELS + 1) : 1;
  localparam int DEPTH = (LOG_LEVELS + 1) << NW;
  localparam int AW    = LW + NW;

  logic [bllca_pkg::ENTRY_W-1:0] mem [DEPTH];
  logic [bllca_pkg::ENTRY_W-1:0] rd_q_r;
  logic                          rd_oor_r;
  logic [AW-1:0]                 rd_addr;
  logic [AW-1:0]                 wr_addr;

  assign rd_addr = {LW'(req.rd_lvl), NW'(req.rd_node)};
  assign wr_addr = {LW'(req.wr_lvl), NW'(req.wr_node)};

  always_ff @(posedge clk) begin
    if (req.wr_en) mem[wr_addr] <= req.wr_data;
    if (req.rd_en) begin
      rd_q_r   <= mem[rd_addr];
      rd_oor_r <= (32'(req.rd_node) >= NODES);
    end
  end

  // a node outside the tree has no ancestors
  assign rd_data = rd_oor_r ? '0 : rd_q_r;
endmodule

// ===== rtl/core/bllca_depth.sv =====
// Depth store memory, one entry per node, registered read.
module bllca_depth #(
  parameter int NODES = bllca_pkg::NODES_DEF
) (
  input  logic                           clk,
  input  bllca_pkg::dep_req_t            req,
  output logic [bllca_pkg::DEPTH_W-1:0]  rd_data
);
  localparam int NW = (NODES > 1) ? $clog2(NODES) : 1;

  logic [bllca_pkg::DEPTH_W-1:0] mem [NODES];
  logic [bllca_pkg::DEPTH_W-1:0] rd_q_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) mem[NW'(req.wr_node)] <= req.wr_data;
    if (req.rd_en) rd_q_r <= mem[NW'(req.rd_node)];
  end

  assign rd_data = rd_q_r;
endmodule

// ===== rtl/core/binary_lifting_lca.sv =====
// Top level of the binary lifting LCA engine: sequencer and handshakes.
//
// Input beats carry in_tuser = opcode (load, build, query) and in_tdata with
// the node fields. A load beat writes one node's parent entry and depth. A
// build beat fills levels 1..LOG_LEVELS of the ancestor table for nodes
// below node_count (at most NODES); for each entry it reads the node's entry
// one level down and, if that is valid, the entry of that ancestor, through
// the single table read port, then writes the new entry. A query beat reads
// both depths and orders the nodes, lifts the deeper node one step per set
// bit of the depth difference, tests for a match, descends up to
// LOG_LEVELS + 1 levels with two table reads and a compare each, reads the
// final parent and posts the result. The single table read port makes these
// steps sequential. in_tready is high only while the sequencer waits for work.
// Each query returns one out beat: tdata = ancestor and found. The result
// sits in an output register; a stalled receiver holds it, and the engine
// accepts more work until another query result needs the register.
// Reset (rst_n low, synchronous) returns the sequencer to idle, clears the
// output valid and sets node_count to 1024; table contents are unaffected.
// cfg_we writes node_count from cfg_wdata. Writing it only while the engine
// is idle is up to the user; the block itself does not enforce it.
module binary_lifting_lca #(
  parameter int NODES      = bllca_pkg::NODES_DEF,
  parameter int LOG_LEVELS = bllca_pkg::LOG_LEVELS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // node_a [9:0], node_b [19:10], has_parent [20], depth [30:21]
  input  logic [bllca_pkg::IN_DATA_W-1:0]    in_tdata,
  // opcode [1:0]
  input  logic [bllca_pkg::OP_W-1:0]         in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // ancestor [9:0], found [10]
  output logic [bllca_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  logic                               cfg_we,
  input  logic [bllca_pkg::CNT_W-1:0]        cfg_wdata
);
  localparam int CW  = $clog2(NODES + 1);
  localparam int NDW = bllca_pkg::NODE_W;
  localparam int LVW = bllca_pkg::LVL_W;
  localparam logic [LVW-1:0] LTOP = LVW'(LOG_LEVELS);

  bllca_pkg::state_t state_r, state_nxt;

  logic [bllca_pkg::CNT_W-1:0]  node_count_r;
  logic [NDW-1:0]               a_r, a_nxt, b_r, b_nxt;
  logic [bllca_pkg::DEPTH_W-1:0] d_r, d_nxt, da_r, da_nxt;
  logic [LVW-1:0]               k_r, k_nxt;
  logic [CW-1:0]                i_r, i_nxt;
  logic [bllca_pkg::ENTRY_W-1:0] ea_r, ea_nxt;
  logic [NDW-1:0]               res_anc_r, res_anc_nxt;
  logic                         res_fnd_r, res_fnd_nxt;
  logic                         out_valid_r;
  logic [NDW-1:0]               out_anc_r;
  logic                         out_fnd_r;

  bllca_pkg::tbl_req_t          treq;
  bllca_pkg::dep_req_t          dreq;
  logic [bllca_pkg::ENTRY_W-1:0] trd;
  logic [bllca_pkg::DEPTH_W-1:0] drd;

  logic [NDW-1:0]  f_a, f_b, f_dp;
  logic            f_hp;
  logic            acc;
  logic            a_oor, b_oor;
  logic            build_done;
  logic [31:0]     lim;
  logic [LVW-1:0]  lift_pos, lift_lvl;
  logic            e_v;
  logic [NDW-1:0]  e_n;

  assign f_a  = in_tdata[9:0];
  assign f_b  = in_tdata[19:10];
  assign f_hp = in_tdata[20];
  assign f_dp = in_tdata[30:21];

  assign in_tready = (state_r == bllca_pkg::S_IDLE);
  assign acc       = in_tvalid && in_tready;
  assign a_oor     = (32'(f_a) >= NODES);
  assign b_oor     = (32'(f_b) >= NODES);
  assign lim       = (32'(node_count_r) > NODES) ? NODES : 32'(node_count_r);
  assign build_done = (32'(i_r) >= lim);
  assign lift_pos  = bllca_pkg::msb_pos(d_r);
  assign lift_lvl  = (32'(lift_pos) > LOG_LEVELS) ? LTOP : lift_pos;
  assign e_v       = trd[NDW];
  assign e_n       = trd[NDW-1:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bllca_pkg::S_IDLE: begin
        if (acc) begin
          priority if (in_tuser == bllca_pkg::OP_BUILD) state_nxt = bllca_pkg::S_B_CHK;
          else if (in_tuser == bllca_pkg::OP_QUERY) begin
            state_nxt = (a_oor || b_oor) ? bllca_pkg::S_OUT : bllca_pkg::S_Q_DB;
          end
          else state_nxt = bllca_pkg::S_IDLE;
        end
      end
      bllca_pkg::S_B_CHK: begin
        if (!build_done) state_nxt = bllca_pkg::S_B_RD2;
        else if (k_r == LTOP) state_nxt = bllca_pkg::S_IDLE;
      end
      bllca_pkg::S_B_RD2:  state_nxt = e_v ? bllca_pkg::S_B_WR : bllca_pkg::S_B_CHK;
      bllca_pkg::S_B_WR:   state_nxt = bllca_pkg::S_B_CHK;
      bllca_pkg::S_Q_DB:   state_nxt = bllca_pkg::S_Q_SW;
      bllca_pkg::S_Q_SW:   state_nxt = bllca_pkg::S_Q_LIFT;
      bllca_pkg::S_Q_LIFT: begin
        if (d_r != '0) state_nxt = bllca_pkg::S_Q_LIFTW;
        else state_nxt = (a_r == b_r) ? bllca_pkg::S_OUT : bllca_pkg::S_Q_DSA;
      end
      bllca_pkg::S_Q_LIFTW: state_nxt = e_v ? bllca_pkg::S_Q_LIFT : bllca_pkg::S_OUT;
      bllca_pkg::S_Q_DSA:  state_nxt = bllca_pkg::S_Q_DSB;
      bllca_pkg::S_Q_DSB:  state_nxt = bllca_pkg::S_Q_DCMP;
      bllca_pkg::S_Q_DCMP: begin
        if ((ea_r != trd) && (!ea_r[NDW] || !e_v)) state_nxt = bllca_pkg::S_OUT;
        else if (k_r == '0) state_nxt = bllca_pkg::S_Q_TOP;
        else state_nxt = bllca_pkg::S_Q_DSA;
      end
      bllca_pkg::S_Q_TOP:  state_nxt = bllca_pkg::S_Q_TOPW;
      bllca_pkg::S_Q_TOPW: state_nxt = bllca_pkg::S_OUT;
      bllca_pkg::S_OUT: begin
        if (!out_valid_r || out_tready) state_nxt = bllca_pkg::S_IDLE;
      end
      default: state_nxt = bllca_pkg::S_IDLE;
    endcase
  end

  // datapath and memory requests
  always_comb begin
    a_nxt = a_r; b_nxt = b_r; d_nxt = d_r; da_nxt = da_r;
    k_nxt = k_r; i_nxt = i_r; ea_nxt = ea_r;
    res_anc_nxt = res_anc_r; res_fnd_nxt = res_fnd_r;
    treq = '0;
    dreq = '0;
    unique case (state_r)
      bllca_pkg::S_IDLE: begin
        if (acc) begin
          a_nxt = f_a;
          b_nxt = f_b;
          i_nxt = '0;
          k_nxt = LVW'(1);
          res_anc_nxt = '0;
          res_fnd_nxt = 1'b0;
          if (in_tuser == bllca_pkg::OP_LOAD && !a_oor) begin
            treq.wr_en   = 1'b1;
            treq.wr_lvl  = '0;
            treq.wr_node = bllca_pkg::NADDR_W'(f_a);
            treq.wr_data = f_hp ? {1'b1, f_b} : '0;
            dreq.wr_en   = 1'b1;
            dreq.wr_node = f_a;
            dreq.wr_data = f_dp;
          end
          if (in_tuser == bllca_pkg::OP_QUERY) begin
            dreq.rd_en   = 1'b1;
            dreq.rd_node = f_a;
          end
        end
      end
      bllca_pkg::S_B_CHK: begin
        if (!build_done) begin
          treq.rd_en   = 1'b1;
          treq.rd_lvl  = k_r - LVW'(1);
          treq.rd_node = bllca_pkg::NADDR_W'(i_r);
        end else if (k_r != LTOP) begin
          k_nxt = k_r + LVW'(1);
          i_nxt = '0;
        end
      end
      bllca_pkg::S_B_RD2: begin
        if (e_v) begin
          treq.rd_en   = 1'b1;
          treq.rd_lvl  = k_r - LVW'(1);
          treq.rd_node = bllca_pkg::NADDR_W'(e_n);
        end else begin
          treq.wr_en   = 1'b1;
          treq.wr_lvl  = k_r;
          treq.wr_node = bllca_pkg::NADDR_W'(i_r);
          treq.wr_data = '0;
          i_nxt = i_r + CW'(1);
        end
      end
      bllca_pkg::S_B_WR: begin
        treq.wr_en   = 1'b1;
        treq.wr_lvl  = k_r;
        treq.wr_node = bllca_pkg::NADDR_W'(i_r);
        treq.wr_data = trd;
        i_nxt = i_r + CW'(1);
      end
      bllca_pkg::S_Q_DB: begin
        da_nxt = drd;
        dreq.rd_en   = 1'b1;
        dreq.rd_node = b_r;
      end
      bllca_pkg::S_Q_SW: begin
        // make b the deeper node
        if (drd < da_r) begin
          a_nxt = b_r;
          b_nxt = a_r;
          d_nxt = da_r - drd;
        end else begin
          d_nxt = drd - da_r;
        end
      end
      bllca_pkg::S_Q_LIFT: begin
        if (d_r != '0) begin
          treq.rd_en   = 1'b1;
          treq.rd_lvl  = lift_lvl;
          treq.rd_node = bllca_pkg::NADDR_W'(b_r);
          k_nxt = lift_lvl;
        end else if (a_r == b_r) begin
          res_anc_nxt = a_r;
          res_fnd_nxt = 1'b1;
        end else begin
          k_nxt = LTOP;
        end
      end
      bllca_pkg::S_Q_LIFTW: begin
        b_nxt = e_n;
        d_nxt = d_r - (bllca_pkg::DEPTH_W'(1) << k_r);
      end
      bllca_pkg::S_Q_DSA: begin
        treq.rd_en   = 1'b1;
        treq.rd_lvl  = k_r;
        treq.rd_node = bllca_pkg::NADDR_W'(a_r);
      end
      bllca_pkg::S_Q_DSB: begin
        ea_nxt = trd;
        treq.rd_en   = 1'b1;
        treq.rd_lvl  = k_r;
        treq.rd_node = bllca_pkg::NADDR_W'(b_r);
      end
      bllca_pkg::S_Q_DCMP: begin
        if (ea_r != trd) begin
          a_nxt = ea_r[NDW-1:0];
          b_nxt = e_n;
        end
        if (k_r != '0) k_nxt = k_r - LVW'(1);
      end
      bllca_pkg::S_Q_TOP: begin
        treq.rd_en   = 1'b1;
        treq.rd_lvl  = '0;
        treq.rd_node = bllca_pkg::NADDR_W'(a_r);
      end
      bllca_pkg::S_Q_TOPW: begin
        if (e_v) begin
          res_anc_nxt = e_n;
          res_fnd_nxt = 1'b1;
        end
      end
      bllca_pkg::S_OUT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= bllca_pkg::S_IDLE;
      node_count_r <= bllca_pkg::NODE_COUNT_RST;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) node_count_r <= cfg_wdata;
      if (state_r == bllca_pkg::S_OUT && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt; b_r <= b_nxt; d_r <= d_nxt; da_r <= da_nxt;
    k_r <= k_nxt; i_r <= i_nxt; ea_r <= ea_nxt;
    res_anc_r <= res_anc_nxt;
    res_fnd_r <= res_fnd_nxt;
    if (state_r == bllca_pkg::S_OUT && (!out_valid_r || out_tready)) begin
      out_anc_r <= res_anc_r;
      out_fnd_r <= res_fnd_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_fnd_r, out_anc_r};

  bllca_table #(.NODES(NODES), .LOG_LEVELS(LOG_LEVELS)) u_table (
    .clk     (clk),
    .req     (treq),
    .rd_data (trd)
  );

  bllca_depth #(.NODES(NODES)) u_depth (
    .clk     (clk),
    .req     (dreq),
    .rd_data (drd)
  );
endmodule
